/* src/isots_pkg.sv */
`default_nettype none

package isots_pkg;

  // Default number of fraction digits kept
  localparam int FRAC_DIGITS_DEFAULT = 9;
  // Largest fraction digit count the scaling table supports
  localparam int MAX_FRAC_DIGITS     = 9;

  localparam int POS_W   = 5;
  localparam int YEAR_W  = 14;
  localparam int FIELD_W = 7;
  localparam int NANO_W  = 30;
  localparam int SEC_W   = 40;

  localparam logic [POS_W-1:0] DATE_LEN   = 5'd19;
  localparam logic [POS_W-1:0] POS_MAX    = 5'd31;
  localparam logic [POS_W-1:0] POS_DASH1  = 5'd4;
  localparam logic [POS_W-1:0] POS_DASH2  = 5'd7;
  localparam logic [POS_W-1:0] POS_T      = 5'd10;
  localparam logic [POS_W-1:0] POS_COLON1 = 5'd13;
  localparam logic [POS_W-1:0] POS_COLON2 = 5'd16;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Register levels between the parser and the finished result
  localparam int CALC_STEPS = 7;
  localparam int STEP_W     = 3;

  typedef enum logic [2:0] {
    ST_RECV = 3'b001,
    ST_CALC = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    TAIL_DOT  = 2'd0,
    TAIL_FRAC = 2'd1,
    TAIL_SKIP = 2'd2
  } tail_t;

  typedef struct packed {
    logic take;
    logic clear;
    logic load_out;
  } cmd_t;

  function automatic logic [NANO_W-1:0] pow10(input logic [3:0] idx);
    logic [NANO_W-1:0] val;
    case (idx)
      4'd0:    val = 30'd1;
      4'd1:    val = 30'd10;
      4'd2:    val = 30'd100;
      4'd3:    val = 30'd1000;
      4'd4:    val = 30'd10000;
      4'd5:    val = 30'd100000;
      4'd6:    val = 30'd1000000;
      4'd7:    val = 30'd10000000;
      4'd8:    val = 30'd100000000;
      4'd9:    val = 30'd1000000000;
      default: val = 30'd1;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

/* src/iso8601_timestamp_to_epoch_ns_top.sv */
// ISO-8601 timestamp to signed nanoseconds since 1970-01-01T00:00:00.
//
// Input channel (s_axis): one text byte per beat. tdata carries the byte,
// tlast marks the final byte of a timestamp "YYYY-MM-DDTHH:MM:SS[.fff...]".
// Output channel (m_axis): one beat per timestamp, issued for the beat that
// carried tlast. tdata is the nanosecond count (wraps at 64 bits), tuser[0]
// is set when the text parsed; a short or malformed string gives 0 with
// tuser[0] clear. Up to FRACTION_DIGITS fraction digits are kept.
//
// Throughput: one byte per cycle while a string streams in. After the tlast
// beat the date arithmetic runs through a 7-step register chain before the
// result is loaded into the output register; s_axis_tready stays low until
// that load.
// Stall: the result waits in the output register; bytes of the next string
// are still taken, but its result leaves only once the previous one is taken.
// Reset (rst, synchronous): clears the parser, the controller and any
// pending output beat.
`default_nettype none

module iso8601_timestamp_to_epoch_ns_top #(
  parameter int FRACTION_DIGITS = isots_pkg::FRAC_DIGITS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Input beats
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,   // [7:0] char_code
  input  wire logic               s_axis_tlast,   // is_last
  // Result beats
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic signed [63:0]      m_axis_tdata,   // [63:0] epoch_ns
  output logic [0:0]              m_axis_tuser    // [0] valid_res
);

  isots_pkg::cmd_t cmd;
  logic            valid_res;

  // Sequencer: input handshake, arithmetic step count, output handshake
  isots_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .cmd           (cmd)
  );

  // Parser, date arithmetic chain and output register
  isots_dp #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .char_code (s_axis_tdata),
    .epoch_ns  (m_axis_tdata),
    .valid_res (valid_res)
  );

  assign m_axis_tuser = valid_res;

endmodule

`default_nettype wire

/* src/isots_ctrl.sv */
`default_nettype none

module isots_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  input  wire logic          s_axis_tlast,
  output logic               s_axis_tready,
  input  wire logic          m_axis_tready,
  output logic               m_axis_tvalid,
  output isots_pkg::cmd_t    cmd
);

  isots_pkg::state_t               state, state_next;
  logic [isots_pkg::STEP_W-1:0]    step, step_next;
  logic                            beat;
  logic                            out_free;

  assign s_axis_tready = (state == isots_pkg::ST_RECV);
  assign beat          = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    cmd.take     = beat;
    cmd.load_out = (state == isots_pkg::ST_DONE) && out_free;
    cmd.clear    = cmd.load_out;
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      isots_pkg::ST_RECV: begin
        if (beat && s_axis_tlast) begin
          state_next = isots_pkg::ST_CALC;
          step_next  = '0;
        end
      end
      isots_pkg::ST_CALC: begin
        if (step == isots_pkg::STEP_W'(isots_pkg::CALC_STEPS - 1)) begin
          state_next = isots_pkg::ST_DONE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      isots_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = isots_pkg::ST_RECV;
        end
      end
      default: begin
        state_next = isots_pkg::ST_RECV;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= isots_pkg::ST_RECV;
      step          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (cmd.load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* src/isots_dp.sv */
`default_nettype none

module isots_dp #(
  parameter int FRACTION_DIGITS = isots_pkg::FRAC_DIGITS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire isots_pkg::cmd_t        cmd,
  input  wire logic [7:0]             char_code,
  output logic signed [63:0]          epoch_ns,
  output logic                        valid_res
);

  localparam int FracW = $clog2(10 ** FRACTION_DIGITS);
  localparam int CntW  = $clog2(FRACTION_DIGITS + 1);
  localparam int FW    = isots_pkg::FIELD_W;
  localparam int SW    = isots_pkg::SEC_W;

  // ---------------- character parser ----------------
  logic [isots_pkg::POS_W-1:0]  position, position_next;
  logic [isots_pkg::YEAR_W-1:0] year_acc, year_acc_next;
  logic [FW-1:0]                month_acc, month_acc_next;
  logic [FW-1:0]                day_acc, day_acc_next;
  logic [FW-1:0]                hour_acc, hour_acc_next;
  logic [FW-1:0]                minute_acc, minute_acc_next;
  logic [FW-1:0]                second_acc, second_acc_next;
  logic [FracW-1:0]             fraction_acc, fraction_acc_next;
  logic [CntW-1:0]              fraction_count, fraction_count_next;
  isots_pkg::tail_t             tail_phase, tail_phase_next;
  logic                         format_error, format_error_next;

  logic       is_dig;
  logic [3:0] dv;

  assign is_dig = (char_code >= isots_pkg::CH_ZERO) && (char_code <= isots_pkg::CH_NINE);
  assign dv     = is_dig ? char_code[3:0] : 4'd0;

  always_comb begin
    position_next       = position;
    year_acc_next       = year_acc;
    month_acc_next      = month_acc;
    day_acc_next        = day_acc;
    hour_acc_next       = hour_acc;
    minute_acc_next     = minute_acc;
    second_acc_next     = second_acc;
    fraction_acc_next   = fraction_acc;
    fraction_count_next = fraction_count;
    tail_phase_next     = tail_phase;
    format_error_next   = format_error;

    if (position < isots_pkg::DATE_LEN) begin
      if (position == isots_pkg::POS_DASH1 || position == isots_pkg::POS_DASH2) begin
        if (char_code != isots_pkg::CH_DASH) format_error_next = 1'b1;
      end else if (position == isots_pkg::POS_T) begin
        if (char_code != isots_pkg::CH_T) format_error_next = 1'b1;
      end else if (position == isots_pkg::POS_COLON1 ||
                   position == isots_pkg::POS_COLON2) begin
        if (char_code != isots_pkg::CH_COLON) format_error_next = 1'b1;
      end else if (!is_dig) begin
        format_error_next = 1'b1;
      end else if (position < isots_pkg::POS_DASH1) begin
        year_acc_next = isots_pkg::YEAR_W'(year_acc * 4'd10 + dv);
      end else if (position < isots_pkg::POS_DASH2) begin
        month_acc_next = FW'(month_acc * 4'd10 + dv);
      end else if (position < isots_pkg::POS_T) begin
        day_acc_next = FW'(day_acc * 4'd10 + dv);
      end else if (position < isots_pkg::POS_COLON1) begin
        hour_acc_next = FW'(hour_acc * 4'd10 + dv);
      end else if (position < isots_pkg::POS_COLON2) begin
        minute_acc_next = FW'(minute_acc * 4'd10 + dv);
      end else begin
        second_acc_next = FW'(second_acc * 4'd10 + dv);
      end
    end else if (tail_phase == isots_pkg::TAIL_DOT) begin
      tail_phase_next = (char_code == isots_pkg::CH_DOT) ? isots_pkg::TAIL_FRAC
                                                         : isots_pkg::TAIL_SKIP;
    end else if (tail_phase == isots_pkg::TAIL_FRAC) begin
      if (!is_dig) begin
        tail_phase_next = isots_pkg::TAIL_SKIP;
      end else if (fraction_count < CntW'(FRACTION_DIGITS)) begin
        fraction_acc_next   = FracW'(fraction_acc * 4'd10 + dv);
        fraction_count_next = fraction_count + 1'b1;
      end
    end

    if (position != isots_pkg::POS_MAX) position_next = position + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      position       <= '0;
      year_acc       <= '0;
      month_acc      <= '0;
      day_acc        <= '0;
      hour_acc       <= '0;
      minute_acc     <= '0;
      second_acc     <= '0;
      fraction_acc   <= '0;
      fraction_count <= '0;
      tail_phase     <= isots_pkg::TAIL_DOT;
      format_error   <= 1'b0;
    end else if (cmd.take) begin
      position       <= position_next;
      year_acc       <= year_acc_next;
      month_acc      <= month_acc_next;
      day_acc        <= day_acc_next;
      hour_acc       <= hour_acc_next;
      minute_acc     <= minute_acc_next;
      second_acc     <= second_acc_next;
      fraction_acc   <= fraction_acc_next;
      fraction_count <= fraction_count_next;
      tail_phase     <= tail_phase_next;
      format_error   <= format_error_next;
    end
  end

  // ---------------- date arithmetic, one register level per step ----------------
  // Parser fields stay stable while the chain settles.

  // Step A: shift year for Jan/Feb, era = floor(y / 400), 153 * mp + 2, fraction scale
  logic                   m_le2;
  logic signed [14:0]     y_adj;
  logic [26:0]            era_prod;
  logic [FW-1:0]          mp;
  logic signed [5:0]      a_era;
  logic signed [14:0]     a_y;
  logic [13:0]            a_t153;
  logic [isots_pkg::NANO_W-1:0] a_nanos;

  assign m_le2    = (month_acc <= 7'd2);
  assign y_adj    = $signed({1'b0, year_acc}) - $signed({14'd0, m_le2});
  // y / 400 as y * 5243 >> 21, exact for y below 10000
  assign era_prod = 27'(y_adj[13:0]) * 27'(13'd5243);
  assign mp       = (month_acc > 7'd2) ? (month_acc - 7'd3) : (month_acc + 7'd9);

  always_ff @(posedge clk) begin
    a_era   <= y_adj[14] ? -6'sd1 : $signed({1'b0, era_prod[25:21]});
    a_y     <= y_adj;
    a_t153  <= 14'(mp) * 14'd153 + 14'd2;
    a_nanos <= isots_pkg::NANO_W'(fraction_acc *
               isots_pkg::pow10(4'(isots_pkg::MAX_FRAC_DIGITS) - 4'(fraction_count)));
  end

  // Step B: year of era, day of year, time of day in seconds
  logic signed [15:0]     yoe_full;
  logic [29:0]            q5_prod;
  logic signed [5:0]      b_era;
  logic [8:0]             b_yoe;
  logic signed [12:0]     b_doy;
  logic [18:0]            b_hms;
  logic [isots_pkg::NANO_W-1:0] b_nanos;

  assign yoe_full = $signed({a_y[14], a_y}) - $signed(a_era) * 16'sd400;
  // (153 * mp + 2) / 5 as x * 52429 >> 18
  assign q5_prod  = 30'(a_t153) * 30'(16'd52429);

  always_ff @(posedge clk) begin
    b_era   <= a_era;
    b_yoe   <= yoe_full[8:0];
    b_doy   <= $signed({1'b0, q5_prod[29:18]}) + $signed({6'd0, day_acc}) - 13'sd1;
    b_hms   <= 19'(hour_acc) * 19'd3600 + 19'(minute_acc) * 19'd60 + 19'(second_acc);
    b_nanos <= a_nanos;
  end

  // Step C: day of era and era offset
  logic [1:0]             yoe_d100;
  logic [17:0]            doe_u;
  logic signed [18:0]     c_doe;
  logic signed [23:0]     c_era_days;
  logic [18:0]            c_hms;
  logic [isots_pkg::NANO_W-1:0] c_nanos;

  always_comb begin
    if (b_yoe >= 9'd300)      yoe_d100 = 2'd3;
    else if (b_yoe >= 9'd200) yoe_d100 = 2'd2;
    else if (b_yoe >= 9'd100) yoe_d100 = 2'd1;
    else                      yoe_d100 = 2'd0;
  end

  assign doe_u = 18'(b_yoe) * 18'd365 + 18'(b_yoe[8:2]) - 18'(yoe_d100);

  always_ff @(posedge clk) begin
    c_doe      <= $signed({1'b0, doe_u}) + 19'(b_doy);
    c_era_days <= 24'(b_era) * 24'sd146097;
    c_hms      <= b_hms;
    c_nanos    <= b_nanos;
  end

  // Step D: days since 1970
  logic signed [23:0]     d_days;
  logic [18:0]            d_hms;
  logic [isots_pkg::NANO_W-1:0] d_nanos;

  always_ff @(posedge clk) begin
    d_days  <= c_era_days + 24'(c_doe) - 24'sd719468;
    d_hms   <= c_hms;
    d_nanos <= c_nanos;
  end

  // Step E: seconds since 1970
  logic signed [SW-1:0]   e_secs;
  logic [isots_pkg::NANO_W-1:0] e_nanos;

  always_ff @(posedge clk) begin
    e_secs  <= SW'(d_days) * SW'(86400) + SW'(d_hms);
    e_nanos <= d_nanos;
  end

  // Step F: seconds times 1e9, split into high and low 20-bit halves
  logic signed [50:0]     phi_full;
  logic [43:0]            f_phi;
  logic [49:0]            f_plo;
  logic [isots_pkg::NANO_W-1:0] f_nanos;

  assign phi_full = $signed(e_secs[SW-1:20]) * 31'sd1000000000;

  always_ff @(posedge clk) begin
    f_phi   <= phi_full[43:0];
    f_plo   <= 50'(e_secs[19:0]) * 50'(30'd1000000000);
    f_nanos <= e_nanos;
  end

  // Step G: recombine, wrapping at 64 bits
  logic [63:0]            g_ns;

  always_ff @(posedge clk) begin
    g_ns <= {f_phi, 20'd0} + 64'(f_plo) + 64'(f_nanos);
  end

  // ---------------- output register ----------------
  logic parse_ok;

  assign parse_ok = (position >= isots_pkg::DATE_LEN) && !format_error;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      epoch_ns  <= parse_ok ? $signed(g_ns) : 64'sd0;
      valid_res <= parse_ok;
    end
  end

endmodule

`default_nettype wire

/* src/isots_chk.sv */
`default_nettype none

module isots_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  // A final byte starts the arithmetic: input must close right after it
  a_last_closes_input: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still open after final beat");

  // Failed parse reports zero nanoseconds
  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 64'd0)
    else $error("invalid result with nonzero data");

  // A new result appears only out of the arithmetic phase
  a_result_after_calc: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result issued while input was open");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

endmodule

bind iso8601_timestamp_to_epoch_ns_top isots_chk u_isots_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* tb/iso8601_timestamp_to_epoch_ns_top_test.sv */
`default_nettype none

module iso8601_timestamp_to_epoch_ns_top_test;

  // Fraction digits the block keeps, at its default setting
  localparam int FRAC_KEEP  = isots_pkg::FRAC_DIGITS_DEFAULT;
  // Input beats to generate before the random part stops
  localparam int BYTE_GOAL  = 1050;
  // Receiver hold-off window, in receiver cycles
  localparam int HOLD_FROM  = 600;
  localparam int HOLD_TO    = 900;
  // Window where neither side idles, in each side's own cycles
  localparam int CALM_FROM  = 1100;
  localparam int CALM_TO    = 1400;
  // Cycles to linger after the last result, well past the date pipeline
  localparam int TAIL_WAIT  = 40;

  // One text byte queued for the driver
  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       drain;  // hold this beat until every pending timestamp is out
  } text_beat_t;

  // One timestamp the block is expected to return
  typedef struct {
    logic signed [63:0] ns;
    logic               ok;
  } stamp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = 8'h00;
  logic               s_axis_tlast  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic signed [63:0] m_axis_tdata;
  logic [0:0]         m_axis_tuser;

  text_beat_t   text_q[$];       // bytes still to send
  stamp_t       pending_stamps[$];  // timestamps in flight, oldest first
  logic [7:0]   frame[$];        // string under construction

  int total_n     = 0;
  int accepted_n  = 0;
  int strings_n   = 0;
  int good_n      = 0;
  int bad_n       = 0;
  int err_n       = 0;
  int tx_cyc      = 0;
  int rx_cyc      = 0;

  // Parser image: position, digit fields, fraction and tail tracking
  logic [isots_pkg::POS_W-1:0]   cur_pos;
  logic [isots_pkg::YEAR_W-1:0]  year_v;
  logic [isots_pkg::FIELD_W-1:0] month_v, day_v, hour_v, min_v, sec_v;
  logic [isots_pkg::NANO_W-1:0]  frac_v;
  logic [3:0]                    frac_cnt;
  isots_pkg::tail_t              tail_v;
  logic                          fmt_bad;

  stamp_t want;

  iso8601_timestamp_to_epoch_ns_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Return the parser image to its idle, cleared state
  task automatic clear_parse();
    cur_pos  = '0;
    year_v   = '0;
    month_v  = '0;
    day_v    = '0;
    hour_v   = '0;
    min_v    = '0;
    sec_v    = '0;
    frac_v   = '0;
    frac_cnt = '0;
    tail_v   = isots_pkg::TAIL_DOT;
    fmt_bad  = 1'b0;
  endtask

  // Fold one accepted byte into the parser image; on the last byte of a string
  // work out the timestamp it should produce and queue it.
  task automatic track_char(input logic [7:0] c, input logic last);
    logic       dig;
    logic [3:0] dv;
    logic [7:0] sep;
    longint     y, m, era, yoe, mp, doy, doe, days, secs, scale;
    stamp_t     s;
    dig = (c >= isots_pkg::CH_ZERO) && (c <= isots_pkg::CH_NINE);
    dv  = dig ? 4'(c - isots_pkg::CH_ZERO) : 4'd0;
    if (cur_pos < isots_pkg::DATE_LEN) begin
      case (cur_pos)
        isots_pkg::POS_DASH1, isots_pkg::POS_DASH2:   sep = isots_pkg::CH_DASH;
        isots_pkg::POS_T:                             sep = isots_pkg::CH_T;
        isots_pkg::POS_COLON1, isots_pkg::POS_COLON2: sep = isots_pkg::CH_COLON;
        default:                                      sep = 8'h00;
      endcase
      if (sep != 8'h00) begin
        if (c != sep) fmt_bad = 1'b1;
      end else if (!dig) begin
        fmt_bad = 1'b1;
      end else if (cur_pos < isots_pkg::POS_DASH1) begin
        year_v = year_v * 10 + dv;
      end else if (cur_pos < isots_pkg::POS_DASH2) begin
        month_v = month_v * 10 + dv;
      end else if (cur_pos < isots_pkg::POS_T) begin
        day_v = day_v * 10 + dv;
      end else if (cur_pos < isots_pkg::POS_COLON1) begin
        hour_v = hour_v * 10 + dv;
      end else if (cur_pos < isots_pkg::POS_COLON2) begin
        min_v = min_v * 10 + dv;
      end else begin
        sec_v = sec_v * 10 + dv;
      end
    end else begin
      case (tail_v)
        isots_pkg::TAIL_DOT: begin
          tail_v = (c == isots_pkg::CH_DOT) ? isots_pkg::TAIL_FRAC
                                            : isots_pkg::TAIL_SKIP;
        end
        isots_pkg::TAIL_FRAC: begin
          if (!dig) begin
            tail_v = isots_pkg::TAIL_SKIP;
          end else if (frac_cnt < FRAC_KEEP) begin
            frac_v   = frac_v * 10 + dv;
            frac_cnt = frac_cnt + 4'd1;
          end
        end
        default: ;
      endcase
    end
    if (cur_pos < isots_pkg::POS_MAX) cur_pos = cur_pos + 5'd1;
    if (last) begin
      s.ns = 64'sd0;
      s.ok = 1'b0;
      if (cur_pos >= isots_pkg::DATE_LEN && !fmt_bad) begin
        // Day count from the civil date: March-based year, 400-year eras
        y = year_v;
        m = month_v;
        if (m <= 2) y = y - 1;
        era  = (y >= 0) ? (y / 400) : ((y - 399) / 400);
        yoe  = y - era * 400;
        mp   = (m > 2) ? (m - 3) : (m + 9);
        doy  = (153 * mp + 2) / 5 + longint'(day_v) - 1;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * 146097 + doe - 719468;
        secs = days * 86400 + longint'(hour_v) * 3600 + longint'(min_v) * 60
               + longint'(sec_v);
        // Pad the kept fraction digits out to nanoseconds
        scale = 1;
        repeat (isots_pkg::MAX_FRAC_DIGITS - int'(frac_cnt)) scale = scale * 10;
        s.ns = secs * 64'sd1000000000 + longint'(frac_v) * scale;
        s.ok = 1'b1;
      end
      pending_stamps.push_back(s);
      clear_parse();
    end
  endtask

  // Append n decimal digits of val to the frame, most significant first
  task automatic push_num(input int val, input int n);
    int pw;
    pw = 1;
    repeat (n - 1) pw = pw * 10;
    repeat (n) begin
      frame.push_back(isots_pkg::CH_ZERO + 8'((val / pw) % 10));
      pw = pw / 10;
    end
  endtask

  // Move the frame into the send queue; tlast goes on its final byte
  task automatic put_frame(input logic drain);
    text_beat_t b;
    foreach (frame[i]) begin
      b.ch    = frame[i];
      b.last  = (i == frame.size() - 1);
      b.drain = drain && (i == 0);
      text_q.push_back(b);
    end
    total_n   += frame.size();
    strings_n += 1;
    frame.delete();
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
    put_frame(1'b0);
  endtask

  // Build a well-formed date-time body, plausible or with any digits at all
  task automatic make_stamp(input logic plausible);
    if (plausible) begin
      push_num($urandom_range(0, 9999), 4); frame.push_back(isots_pkg::CH_DASH);
      push_num($urandom_range(1, 12), 2);   frame.push_back(isots_pkg::CH_DASH);
      push_num($urandom_range(1, 31), 2);   frame.push_back(isots_pkg::CH_T);
      push_num($urandom_range(0, 23), 2);   frame.push_back(isots_pkg::CH_COLON);
      push_num($urandom_range(0, 59), 2);   frame.push_back(isots_pkg::CH_COLON);
      push_num($urandom_range(0, 59), 2);
    end else begin
      push_num($urandom_range(0, 9999), 4); frame.push_back(isots_pkg::CH_DASH);
      push_num($urandom_range(0, 99), 2);   frame.push_back(isots_pkg::CH_DASH);
      push_num($urandom_range(0, 99), 2);   frame.push_back(isots_pkg::CH_T);
      push_num($urandom_range(0, 99), 2);   frame.push_back(isots_pkg::CH_COLON);
      push_num($urandom_range(0, 99), 2);   frame.push_back(isots_pkg::CH_COLON);
      push_num($urandom_range(0, 99), 2);
    end
  endtask

  // Append a random tail: none, a fraction of any length, or junk
  task automatic make_tail();
    case ($urandom_range(0, 5))
      0: ;
      1, 2: begin
        frame.push_back(isots_pkg::CH_DOT);
        repeat ($urandom_range(1, FRAC_KEEP)) push_num($urandom_range(0, 9), 1);
      end
      3: begin
        frame.push_back(isots_pkg::CH_DOT);
        repeat ($urandom_range(FRAC_KEEP + 1, 14)) push_num($urandom_range(0, 9), 1);
      end
      4: begin
        frame.push_back(isots_pkg::CH_DOT);
        repeat ($urandom_range(0, 5)) push_num($urandom_range(0, 9), 1);
        repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
      end
      default: repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  // Sender: hand a byte to the block whenever the slot is free, idling at
  // random outside the calm window, and hold any beat marked to drain until
  // the block has returned every timestamp owed.
  always @(posedge clk) begin
    tx_cyc = tx_cyc + 1;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_char(s_axis_tdata, s_axis_tlast);
        accepted_n = accepted_n + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (text_q.size() != 0
            && !(text_q[0].drain && pending_stamps.size() != 0)
            && ((tx_cyc >= CALM_FROM && tx_cyc < CALM_TO)
                || $urandom_range(0, 99) >= 25)) begin
          s_axis_tdata  <= text_q[0].ch;
          s_axis_tlast  <= text_q[0].last;
          s_axis_tvalid <= 1'b1;
          void'(text_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: hold off completely for a long window so the output register
  // backs up into the input, never stall in the calm window, else stall at
  // random.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cyc = rx_cyc + 1;
      if (rx_cyc >= HOLD_FROM && rx_cyc < HOLD_TO)
        m_axis_tready <= 1'b0;
      else if (rx_cyc >= CALM_FROM && rx_cyc < CALM_TO)
        m_axis_tready <= 1'b1;
      else
        m_axis_tready <= ($urandom_range(0, 99) >= 25);
    end
  end

  // Monitor: check each result beat against the oldest pending timestamp
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_stamps.size() == 0) begin
        err_n = err_n + 1;
        $display("%0t: unexpected result beat, epoch_ns %0d valid %0b",
                 $time, m_axis_tdata, m_axis_tuser[0]);
      end else begin
        want = pending_stamps.pop_front();
        if (m_axis_tdata !== want.ns) begin
          err_n = err_n + 1;
          $display("%0t: epoch_ns mismatch, expected %0d, got %0d",
                   $time, want.ns, m_axis_tdata);
        end
        if (m_axis_tuser[0] !== want.ok) begin
          err_n = err_n + 1;
          $display("%0t: valid mismatch, expected %0b, got %0b",
                   $time, want.ok, m_axis_tuser[0]);
        end
        if (want.ok) good_n = good_n + 1;
        else bad_n = bad_n + 1;
      end
    end
  end

  initial begin
    int    kind;
    string tail_src;
    clear_parse();

    // Directed: epoch origin, field extremes, year zero, fraction
    // handling, tail rules, short strings and every separator broken.
    put_text("1970-01-01T00:00:00");
    put_text("9999-12-31T23:59:59.999999999");
    put_text("0000-01-01T00:00:00");
    put_text("0000-00-00T00:00:00");
    put_text("9999-99-99T99:99:99.123456789012");
    put_text("2024-02-29T12:34:56.5");
    put_text("2024-02-29T12:34:56Z");
    put_text("2024-02-29T12:34:56.12a34");
    put_text("2024-02-29T12:34:56.");
    put_text("2024-02-29T12:34");
    put_text("5");
    put_text("2024/02-29T12:34:56");
    put_text("2024-02/29T12:34:56");
    put_text("20x4-02-29t12:34:56");
    put_text("2024-02-29T12-34:56");
    put_text("2024-02-29T12:34-56");
    put_text("1969-12-31T23:59:59.000000001999999999999999");
    // Ignored tail with bytes of all ones and all zeros, sent after a drain
    tail_src = "1999-01-02T03:04:05";
    for (int i = 0; i < tail_src.len(); i++) frame.push_back(tail_src[i]);
    frame.push_back(8'hFF);
    frame.push_back(8'h00);
    put_frame(1'b1);

    // Random: mostly well-formed timestamps, some broken, some plain noise
    while (total_n < BYTE_GOAL) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        make_stamp(1'($urandom_range(0, 1)));
        make_tail();
      end else if (kind < 85) begin
        make_stamp(1'b1);
        if ($urandom_range(0, 1)) begin
          kind = $urandom_range(1, 18);
          while (frame.size() > kind) void'(frame.pop_back());
        end else begin
          frame[$urandom_range(0, 18)] = 8'($urandom_range(0, 255));
          make_tail();
        end
      end else begin
        repeat ($urandom_range(1, 40)) frame.push_back(8'($urandom_range(0, 255)));
      end
      put_frame(strings_n % 16 == 0);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait for every byte to be taken and every timestamp to come back
    while (!(accepted_n == total_n && pending_stamps.size() == 0)) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Sent %0d bytes in %0d strings; %0d timestamps parsed, %0d rejected.",
             accepted_n, strings_n, good_n, bad_n);
    $display("Covered field extremes, fraction and tail rules, malformed text, a long stall.");
    if (err_n == 0)
      $display("iso8601_timestamp_to_epoch_ns_top_test OK");
    else
      $display("iso8601_timestamp_to_epoch_ns_top_test NOT OK");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #800000;
    $display("iso8601_timestamp_to_epoch_ns_top_test NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

/* iso8601_timestamp_to_epoch_ns_top.f */
src/isots_pkg.sv
src/isots_ctrl.sv
src/isots_dp.sv
src/iso8601_timestamp_to_epoch_ns_top.sv
src/isots_chk.sv
tb/iso8601_timestamp_to_epoch_ns_top_test.sv
